// File: design/bpar_pkg.sv
// bpar_pkg: widths, reset values and register indexes for the button
// priority auto-repeat block. No dependencies.

package bpar_pkg;

    localparam int PIN_W       = 8;   // width of the pin level field
    localparam int IDX_W       = 3;   // width of a button index
    localparam int TIME_W      = 32;  // millisecond timestamp width
    localparam int CFG_W       = 16;  // widest configuration register
    localparam int CFG_IDX_W   = 2;   // configuration register index width
    localparam int COUNT_W     = 16;  // repeat counter width

    // Buttons at or above this index are ignored; only PIN_W bits exist.
    localparam int NUM_BUTTONS  = 8;
    localparam int LIVE_BUTTONS = (NUM_BUTTONS < PIN_W) ? NUM_BUTTONS : PIN_W;

    localparam logic [CFG_W-1:0]   INITIAL_DELAY_RST   = 16'd500;
    localparam logic [CFG_W-1:0]   REPEAT_INTERVAL_RST = 16'd200;
    localparam logic [COUNT_W-1:0] COUNT_MAX           = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL_DELAY   = 2'd0,
        CFG_REPEAT_INTERVAL = 2'd1
    } t_cfg_reg;

endpackage

// File: design/button_priority_auto_repeat.sv
// button_priority_auto_repeat: priority encoder over the button pins with
// typematic auto-repeat timing. Depends on bpar_pkg.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------
//  in      | in        | i_in_valid / o_in_stall | i_pin_levels, i_now_ms
//  out     | out       | o_out_valid / i_out_stall | o_report_valid, o_button_index, o_is_repeat
//  cfg     | in        | i_cfg_we (no wait)      | i_cfg_index, i_cfg_data
//
// One request per cycle sustained while the output is not stalled; each poll
// gives exactly one result, which passes through the input register and then
// the result register.
// The per-poll path is the priority encode plus the 16x16 threshold product
// and the 32-bit elapsed compare, all from registered state.
// Reset is synchronous and clears held-button state, counters and valids.
// A stall on the output holds the result register; the input register then
// fills and o_in_stall rises only while both stages are occupied.

module button_priority_auto_repeat (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [bpar_pkg::PIN_W-1:0]     i_pin_levels,
    input  logic [bpar_pkg::TIME_W-1:0]    i_now_ms,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_report_valid,
    output logic [bpar_pkg::IDX_W-1:0]     o_button_index,
    output logic                           o_is_repeat,
    input  logic                           i_cfg_we,
    input  logic [bpar_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bpar_pkg::CFG_W-1:0]     i_cfg_data
);

    // configuration
    logic [bpar_pkg::CFG_W-1:0]   r_init_delay;
    logic [bpar_pkg::CFG_W-1:0]   r_interval;

    // input register
    logic                         r_s1_valid;
    logic [bpar_pkg::PIN_W-1:0]   r_pins;
    logic [bpar_pkg::TIME_W-1:0]  r_now;

    // held-button state
    logic                         r_act_valid, n_act_valid;
    logic [bpar_pkg::IDX_W-1:0]   r_act_idx, n_act_idx;
    logic [bpar_pkg::TIME_W-1:0]  r_start, n_start;
    logic [bpar_pkg::COUNT_W-1:0] r_count, n_count;

    // result register
    logic                         r_out_valid;
    logic                         r_rep_valid, n_rep_valid;
    logic [bpar_pkg::IDX_W-1:0]   r_rep_idx, n_rep_idx;
    logic                         r_is_rep, n_is_rep;

    logic                         w_advance;
    logic                         w_process;
    logic                         w_found;
    logic [bpar_pkg::IDX_W-1:0]   w_idx;
    logic                         w_changed;
    logic [bpar_pkg::TIME_W-1:0]  w_elapsed;
    logic [bpar_pkg::TIME_W-1:0]  w_prod;
    logic [bpar_pkg::TIME_W-1:0]  w_thresh;
    logic                         w_hit;

    assign w_advance  = !r_out_valid || !i_out_stall;
    assign w_process  = r_s1_valid && w_advance;
    assign o_in_stall = r_s1_valid && !w_advance;

    // lowest index wins: scan from the top so the lowest pressed bit is last
    always_comb begin
        w_found = 1'b0;
        w_idx   = '0;
        for (int i = bpar_pkg::LIVE_BUTTONS - 1; i >= 0; i--) begin
            if (!r_pins[i]) begin
                w_found = 1'b1;
                w_idx   = bpar_pkg::IDX_W'(i);
            end
        end
    end

    assign w_changed = (w_found != r_act_valid) || (w_found && (w_idx != r_act_idx));
    assign w_elapsed = r_now - r_start;
    // product fits 32 bits exactly for 16-bit operands
    assign w_prod    = {16'b0, r_count} * {16'b0, r_interval};
    assign w_thresh  = (r_count == '0) ? {16'b0, r_init_delay} : w_prod;
    assign w_hit     = (w_elapsed >= w_thresh);

    always_comb begin
        n_act_valid = r_act_valid;
        n_act_idx   = r_act_idx;
        n_start     = r_start;
        n_count     = r_count;
        n_rep_valid = 1'b0;
        n_rep_idx   = '0;
        n_is_rep    = 1'b0;
        if (w_changed) begin
            n_act_valid = w_found;
            n_act_idx   = w_idx;
            n_start     = w_found ? r_now : '0;
            n_count     = '0;
            n_rep_valid = w_found;
            n_rep_idx   = w_idx;
        end else if (w_found && w_hit) begin
            n_rep_valid = 1'b1;
            n_rep_idx   = w_idx;
            n_is_rep    = 1'b1;
            if (r_count == '0) begin
                n_count = bpar_pkg::COUNT_W'(1);
                n_start = r_start + {16'b0, r_init_delay};
            end else if (r_count != bpar_pkg::COUNT_MAX) begin
                n_count = r_count + bpar_pkg::COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_delay <= bpar_pkg::INITIAL_DELAY_RST;
            r_interval   <= bpar_pkg::REPEAT_INTERVAL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bpar_pkg::CFG_INITIAL_DELAY:   r_init_delay <= i_cfg_data;
                bpar_pkg::CFG_REPEAT_INTERVAL: r_interval   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_pins <= i_pin_levels;
            r_now  <= i_now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_valid <= 1'b0;
            r_act_idx   <= '0;
            r_start     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_process) begin
                r_act_valid <= n_act_valid;
                r_act_idx   <= n_act_idx;
                r_start     <= n_start;
                r_count     <= n_count;
            end
            if (w_advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_process) begin
            r_rep_valid <= n_rep_valid;
            r_rep_idx   <= n_rep_idx;
            r_is_rep    <= n_is_rep;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_report_valid = r_rep_valid;
    assign o_button_index = r_rep_idx;
    assign o_is_repeat    = r_is_rep;

endmodule

// File: design/bpar_checker.sv
// bpar_checker: port-level assertions for button_priority_auto_repeat,
// attached by the bind below. Depends on bpar_pkg.

module bpar_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic                           o_report_valid,
    input logic [bpar_pkg::IDX_W-1:0]     o_button_index,
    input logic                           o_is_repeat
);

    // the input side only backs up when the result register is blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while the output was free");

    // a repeat is always a reported press
    a_repeat_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_repeat) |-> o_report_valid)
        else $error("repeat flagged without a report");

    // an empty result carries zero index and no repeat flag
    a_empty_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_report_valid) |-> (o_button_index == '0 && !o_is_repeat))
        else $error("empty result with stray fields");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_report_valid) && $stable(o_button_index)
             && $stable(o_is_repeat)))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind button_priority_auto_repeat bpar_checker u_bpar_checker (.*);

// File: verif/bpar_checker.sv
// bpar_report_checker: watches the poll, report and register channels of
// button_priority_auto_repeat, predicts each report and compares it.
// Depends on bpar_pkg.

module bpar_report_checker
    import bpar_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [PIN_W-1:0]   i_pin_levels,
    input  logic [TIME_W-1:0]  i_now_ms,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_report_valid,
    input  logic [IDX_W-1:0]   i_button_index,
    input  logic               i_is_repeat,
    input  logic               i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic             rep_valid;
        logic [IDX_W-1:0] index;
        logic             is_rep;
    } t_report;

    // predictor copy of the registers and the held-button state
    logic [CFG_W-1:0]   delay_ms;
    logic [CFG_W-1:0]   interval_ms;
    logic               held_valid;
    logic [IDX_W-1:0]   held_index;
    logic [TIME_W-1:0]  hold_ref_ms;
    logic [COUNT_W-1:0] repeats_seen;

    t_report expected_reports[$];
    t_report predicted;
    t_report observed;
    t_report oldest;
    int      mismatches = 0;

    task automatic predict_report(input logic [PIN_W-1:0] pins, input logic [TIME_W-1:0] now,
                                  output t_report r);
        logic              found;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] thresh;
        found = 1'b0;
        idx   = '0;
        r     = '0;
        // scan downward so the lowest pressed index is left standing
        for (int i = LIVE_BUTTONS - 1; i >= 0; i--) begin
            if (!pins[i]) begin
                found = 1'b1;
                idx   = IDX_W'(i);
            end
        end
        if (found != held_valid || (found && idx != held_index)) begin
            held_valid   = found;
            held_index   = idx;
            hold_ref_ms  = found ? now : '0;
            repeats_seen = '0;
            r.rep_valid  = found;
            r.index      = idx;
        end else if (found) begin
            elapsed = now - hold_ref_ms;
            if (repeats_seen == '0) begin
                if (elapsed >= TIME_W'(delay_ms)) begin
                    repeats_seen = COUNT_W'(1);
                    hold_ref_ms  = hold_ref_ms + TIME_W'(delay_ms);
                    r = '{rep_valid: 1'b1, index: idx, is_rep: 1'b1};
                end
            end else begin
                thresh = TIME_W'(repeats_seen) * TIME_W'(interval_ms);
                if (elapsed >= thresh) begin
                    if (repeats_seen != COUNT_MAX) repeats_seen = repeats_seen + 1'b1;
                    r = '{rep_valid: 1'b1, index: idx, is_rep: 1'b1};
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            delay_ms     = INITIAL_DELAY_RST;
            interval_ms  = REPEAT_INTERVAL_RST;
            held_valid   = 1'b0;
            held_index   = '0;
            hold_ref_ms  = '0;
            repeats_seen = '0;
            expected_reports.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_INITIAL_DELAY: begin
                        delay_ms = i_cfg_data;
                    end
                    CFG_REPEAT_INTERVAL: begin
                        interval_ms = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                predict_report(i_pin_levels, i_now_ms, predicted);
                expected_reports.push_back(predicted);
            end
            if (i_out_valid && !i_out_stall) begin
                observed = '{rep_valid: i_report_valid, index: i_button_index,
                             is_rep: i_is_repeat};
                if (expected_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("report with none pending: valid=%0d index=%0d is_rep=%0d",
                                 observed.rep_valid, observed.index, observed.is_rep);
                end else begin
                    oldest = expected_reports.pop_front();
                    if (observed.rep_valid !== oldest.rep_valid ||
                        observed.index !== oldest.index ||
                        observed.is_rep !== oldest.is_rep) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("report mismatch: exp valid=%0d index=%0d is_rep=%0d, got valid=%0d index=%0d is_rep=%0d",
                                     oldest.rep_valid, oldest.index, oldest.is_rep,
                                     observed.rep_valid, observed.index, observed.is_rep);
                    end
                end
            end
        end
        o_pending    <= expected_reports.size();
        o_fail_count <= mismatches;
    end

endmodule

// File: verif/testbench.sv
// testbench: drives polls and register writes into button_priority_auto_repeat
// and gives the verdict. Depends on bpar_pkg and bpar_report_checker.

module testbench;
    import bpar_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;   // not a register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;   // not a register
    localparam logic [PIN_W-1:0]     PINS_RELEASED = '1;
    localparam int ITEMS_PER_SETTING = 88;
    localparam int LONG_HOLD_POLLS   = 24;
    localparam int HOLD_OFF_CYCLES   = 40;
    localparam int DRAIN_CYCLES      = 8;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic [PIN_W-1:0]     pin_levels  = '1;
    logic [TIME_W-1:0]    now_ms      = '0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    logic                 report_valid;
    logic [IDX_W-1:0]     button_index;
    logic                 is_repeat;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [CFG_W-1:0]     cfg_data    = '0;

    int   fail_count;
    int   pending;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_off       = 1'b0;
    logic pressure_go    = 1'b0;
    logic [CFG_W-1:0] cur_delay    = INITIAL_DELAY_RST;
    logic [CFG_W-1:0] cur_interval = REPEAT_INTERVAL_RST;

    button_priority_auto_repeat u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_pin_levels   (pin_levels),
        .i_now_ms       (now_ms),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_report_valid (report_valid),
        .o_button_index (button_index),
        .o_is_repeat    (is_repeat),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    bpar_report_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_pin_levels   (pin_levels),
        .i_now_ms       (now_ms),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_report_valid (report_valid),
        .i_button_index (button_index),
        .i_is_repeat    (is_repeat),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        out_stall <= hold_off || ($urandom_range(0, 99) < recv_stall_pct);
    end

    // long receiver hold-off so both stages fill and the input stalls
    initial begin
        @(posedge pressure_go);
        repeat (HOLD_OFF_CYCLES) begin
            hold_off <= 1'b1;
            @(posedge i_clk);
        end
        hold_off <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic send_poll(input logic [PIN_W-1:0] pins, input logic [TIME_W-1:0] now);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid   <= 1'b1;
        pin_levels <= pins;
        now_ms     <= now;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    // pending is registered, hence the wait for an edge before looking at it
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] delay, input logic [CFG_W-1:0] interval);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SPARE_A;
        cfg_data  <= CFG_W'($urandom);
        @(posedge i_clk);
        cfg_index <= CFG_SPARE_B;
        cfg_data  <= CFG_W'($urandom);
        @(posedge i_clk);
        cfg_index <= CFG_INITIAL_DELAY;
        cfg_data  <= delay;
        @(posedge i_clk);
        cfg_index <= CFG_REPEAT_INTERVAL;
        cfg_data  <= interval;
        @(posedge i_clk);
        cfg_we       <= 1'b0;
        cur_delay    = delay;
        cur_interval = interval;
    endtask

    initial begin
        int               n;
        int               b;
        int               len;
        int               span;
        logic [PIN_W-1:0] pins;
        logic [TIME_W-1:0] cur_ms;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset timing 500/200: threshold edges on button 0
        send_poll(PINS_RELEASED, 32'd0);
        send_poll(8'hFE, 32'd100);
        send_poll(8'hFE, 32'd599);
        send_poll(8'hFE, 32'd600);
        send_poll(8'hFE, 32'd799);
        send_poll(8'hFE, 32'd800);
        send_poll(8'h00, 32'd900);   // all down, button 0 still wins
        for (int i = 0; i < LIVE_BUTTONS; i++)
            send_poll(~(PIN_W'(1) << i), 32'd1000 + 32'(i));
        send_poll(PINS_RELEASED, 32'd2000);

        // zero delay and interval: repeat on every held poll
        set_config('0, '0);
        send_poll(8'hF7, 32'd5);
        send_poll(8'hF7, 32'd5);
        send_poll(8'hF7, 32'd5);

        // widest timing across the timestamp wrap, then time going backwards
        set_config('1, '1);
        send_poll(8'hFB, 32'hFFFF_FF00);
        send_poll(8'hFB, 32'h0000_FE00);
        send_poll(8'hFB, 32'h0000_FEFF);
        send_poll(8'hFB, 32'h0001_FEFE);
        send_poll(8'hFB, 32'h0001_FEFF);
        send_poll(8'hFB, 32'h0000_0010);
        send_poll(PINS_RELEASED, 32'h0000_0020);

        // build up a repeat count, then check the count-scaled threshold
        set_config('0, '0);
        send_poll(8'hDF, 32'd1000);
        for (int k = 0; k < LONG_HOLD_POLLS; k++)
            send_poll(8'hDF, 32'd1000);
        set_config('0, 16'd1);
        send_poll(8'hDF, 32'd1000 + 32'd23);
        send_poll(8'hDF, 32'd1000 + 32'd24);
        send_poll(8'hDF, 32'd1000 + 32'd25);
        send_poll(PINS_RELEASED, 32'd0);

        cur_ms = $urandom;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 33;
                    recv_stall_pct = 75;
                end
                1: begin
                    send_idle_pct  = 75;
                    recv_stall_pct = 33;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int s = 0; s < 4; s++) begin
                case (s)
                    0: set_config(CFG_W'($urandom_range(1, 40)), CFG_W'($urandom_range(1, 20)));
                    1: set_config('0, CFG_W'($urandom_range(0, 10)));
                    2: set_config('1, '1);
                    default: set_config(CFG_W'($urandom), CFG_W'($urandom));
                endcase
                if (phase == 2 && s == 0) pressure_go <= 1'b1;
                n = 0;
                while (n < ITEMS_PER_SETTING) begin
                    if ($urandom_range(0, 99) < 15) begin
                        // noise: any pins, any timestamp
                        send_poll(PIN_W'($urandom), $urandom);
                        n++;
                    end else begin
                        b    = $urandom_range(0, LIVE_BUTTONS - 1);
                        len  = $urandom_range(2, 16);
                        span = ((cur_delay > cur_interval) ? cur_delay : cur_interval) / 3 + 3;
                        for (int k = 0; k < len; k++) begin
                            // random pins above b, none below, b itself down
                            pins    = PIN_W'($urandom) | ((PIN_W'(1) << b) - PIN_W'(1));
                            pins[b] = 1'b0;
                            send_poll(pins, cur_ms);
                            cur_ms = cur_ms + TIME_W'($urandom_range(0, span));
                            n++;
                        end
                        if ($urandom_range(0, 9) < 4) begin
                            send_poll(PINS_RELEASED, cur_ms);
                            n++;
                        end
                    end
                end
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
